FILE: design/encoder_vfo_tuner_civ_framer_core_defines.svh
// Assertion macros for the checker file of the tuner core.
`ifndef ENCODER_VFO_TUNER_CIV_FRAMER_CORE_DEFINES_SVH
`define ENCODER_VFO_TUNER_CIV_FRAMER_CORE_DEFINES_SVH

// Checked on every clock edge outside reset.
`define EVFC_ASSERT_RUN(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define EVFC_ASSERT_ALL(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: design/evfc_pkg.sv
package evfc_pkg;

   localparam int FREQ_W       = 25;
   localparam int BCD_DIGITS   = 10;
   localparam int BCD_W        = 4 * BCD_DIGITS;
   localparam int STEP_W       = 8;
   localparam int PULSE_W      = 16;
   localparam int STEP_LEVELS  = 10;
   localparam int IDX_W        = $clog2(STEP_LEVELS);
   localparam int CNT_W        = $clog2(BCD_DIGITS);
   // Decimal digits needed for a 25-bit value.
   localparam int FREQ_DIGITS  = 8;
   localparam int DABBLE_STEPS = 5;
   localparam int CONV_CYCLES  = FREQ_W / DABBLE_STEPS;
   localparam int DABBLE_W     = 4 * FREQ_DIGITS + FREQ_W;
   localparam int BYTE_IDX_W   = 4;
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;

   localparam logic [FREQ_W-1:0] FREQ_SAT = {FREQ_W{1'b1}};

   // Input item type codes.
   localparam logic [2:0] REQ_RIGHT  = 3'd0;
   localparam logic [2:0] REQ_LEFT   = 3'd1;
   localparam logic [2:0] REQ_TICK   = 3'd2;
   localparam logic [2:0] REQ_LOAD   = 3'd3;
   localparam logic [2:0] REQ_RESYNC = 3'd4;

   // Register indexes on the configuration port.
   localparam logic [2:0] CSR_RADIO_ADDR = 3'd0;
   localparam logic [2:0] CSR_CTRL_ADDR  = 3'd1;
   localparam logic [2:0] CSR_FREQ_MIN   = 3'd2;
   localparam logic [2:0] CSR_FREQ_MAX   = 3'd3;
   localparam logic [2:0] CSR_PPL        = 3'd4;

   localparam logic [7:0]        RADIO_ADDR_RST = 8'h70;
   localparam logic [7:0]        CTRL_ADDR_RST  = 8'hE0;
   localparam logic [FREQ_W-1:0] FREQ_MIN_RST   = 25'd500000;
   localparam logic [FREQ_W-1:0] FREQ_MAX_RST   = 25'd30000000;
   localparam logic [PULSE_W-1:0] PPL_RST       = 16'd60;

   // Frame bytes.
   localparam logic [7:0] FRM_PREAMBLE = 8'hFE;
   localparam logic [7:0] FRM_CMD_FREQ = 8'h05;
   localparam logic [7:0] FRM_END      = 8'hFD;

   localparam logic [BYTE_IDX_W-1:0] POS_PRE0  = 4'd0;
   localparam logic [BYTE_IDX_W-1:0] POS_PRE1  = 4'd1;
   localparam logic [BYTE_IDX_W-1:0] POS_RADIO = 4'd2;
   localparam logic [BYTE_IDX_W-1:0] POS_CTRL  = 4'd3;
   localparam logic [BYTE_IDX_W-1:0] POS_CMD   = 4'd4;
   localparam logic [BYTE_IDX_W-1:0] POS_FRQ0  = 4'd5;
   localparam logic [BYTE_IDX_W-1:0] POS_FRQ1  = 4'd6;
   localparam logic [BYTE_IDX_W-1:0] POS_FRQ2  = 4'd7;
   localparam logic [BYTE_IDX_W-1:0] POS_FRQ3  = 4'd8;
   localparam logic [BYTE_IDX_W-1:0] POS_FRQ4  = 4'd9;
   localparam logic [BYTE_IDX_W-1:0] POS_END   = 4'd10;

   localparam logic [STEP_W-1:0] STEP_TABLE [16] = '{
      8'd1, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd8, 8'd16,
      8'd64, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
   };

   typedef enum logic [2:0] {
      OP_RIGHT,
      OP_LEFT,
      OP_TICK,
      OP_LOAD,
      OP_BAD_LOAD,
      OP_RESYNC
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [BCD_W-1:0] bcd;
   } cmd_type;

   typedef struct packed {
      logic [7:0]         radio_addr;
      logic [7:0]         ctrl_addr;
      logic [FREQ_W-1:0]  freq_min;
      logic [FREQ_W-1:0]  freq_max;
      logic [PULSE_W-1:0] pulses_per_level;
   } cfg_type;

endpackage

FILE: design/evfc_front.sv
module evfc_front (
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [2:0]                   req_type,
   input  logic [evfc_pkg::BCD_W-1:0]   req_bcd_freq,
   input  logic                         q_full,
   output logic                         push,
   output evfc_pkg::cmd_type            push_cmd
);

   logic digit_bad;
   logic known;

   always_comb begin
      digit_bad = 1'b0;
      for (int d = 0; d < evfc_pkg::BCD_DIGITS; d++) begin
         if (req_bcd_freq[4*d +: 4] > 4'd9) begin
            digit_bad = 1'b1;
         end
      end
   end

   always_comb begin
      known        = 1'b1;
      push_cmd.bcd = req_bcd_freq;
      push_cmd.op  = evfc_pkg::OP_RESYNC;
      unique case (req_type)
         evfc_pkg::REQ_RIGHT:  push_cmd.op = evfc_pkg::OP_RIGHT;
         evfc_pkg::REQ_LEFT:   push_cmd.op = evfc_pkg::OP_LEFT;
         evfc_pkg::REQ_TICK:   push_cmd.op = evfc_pkg::OP_TICK;
         evfc_pkg::REQ_LOAD: begin
            // A zero value is rejected like a bad digit.
            if (digit_bad || req_bcd_freq == '0) begin
               push_cmd.op = evfc_pkg::OP_BAD_LOAD;
            end else begin
               push_cmd.op = evfc_pkg::OP_LOAD;
            end
         end
         evfc_pkg::REQ_RESYNC: push_cmd.op = evfc_pkg::OP_RESYNC;
         default:              known = 1'b0;
      endcase
   end

   // Unknown item types are taken and dropped here.
   assign req_ready = !q_full;
   assign push      = req_valid && req_ready && known;

endmodule

FILE: design/evfc_queue.sv
module evfc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  evfc_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              q_valid,
   output evfc_pkg::cmd_type q_cmd
);

   evfc_pkg::cmd_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign q_cmd   = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: design/evfc_back.sv
module evfc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  evfc_pkg::cfg_type     cfg,
   input  logic                  q_valid,
   input  evfc_pkg::cmd_type     q_cmd,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_frame_byte,
   output logic                  rsp_load_error,
   output logic                  rsp_last_byte
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_DIV   = 7'b0000010,
      ST_LOAD  = 7'b0000100,
      ST_CLAMP = 7'b0001000,
      ST_CONV  = 7'b0010000,
      ST_CMP   = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } state_type;

   localparam int FW = evfc_pkg::FREQ_W;
   localparam int PW = evfc_pkg::PULSE_W;
   localparam int DW = 4 * evfc_pkg::FREQ_DIGITS;

   localparam logic [evfc_pkg::IDX_W-1:0] IDX_MAX =
      evfc_pkg::IDX_W'(evfc_pkg::STEP_LEVELS - 1);

   state_type                          state_ff, state_in;
   logic [FW-1:0]                      raw_ff, raw_in;
   logic [evfc_pkg::STEP_W-1:0]        step_ff, step_in;
   logic [PW-1:0]                      pulse_ff, pulse_in;
   logic                               synced_ff, synced_in;
   logic [DW-1:0]                      last_sent_ff, last_sent_in;
   logic [evfc_pkg::BCD_W-1:0]         bcd_ff, bcd_in;
   logic [evfc_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic [PW-1:0]                      rem_ff, rem_in;
   logic [evfc_pkg::IDX_W-1:0]         idx_ff, idx_in;
   logic [FW-1:0]                      acc_ff, acc_in;
   logic                               sat_ff, sat_in;
   logic [FW-1:0]                      shift_ff, shift_in;
   logic [DW-1:0]                      dig_ff, dig_in;
   logic [evfc_pkg::BYTE_IDX_W-1:0]    byte_idx_ff, byte_idx_in;
   logic                               err_ff, err_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [7:0]                         rsp_byte_ff, rsp_byte_in;
   logic                               rsp_err_ff, rsp_err_in;
   logic                               rsp_last_ff, rsp_last_in;

   logic [FW:0]                        sum;
   logic [PW-1:0]                      divisor;
   logic [FW+3:0]                      acc_next;
   logic [FW-1:0]                      clamped;
   logic [DW-1:0]                      rounded;
   logic [evfc_pkg::DABBLE_W-1:0]      dabble;
   logic [7:0]                         frame_byte;
   logic                               out_free;
   logic                               byte_last;

   // Shift-and-add-3 binary to BCD, several bits per cycle.
   always_comb begin
      dabble = {dig_ff, shift_ff};
      for (int s = 0; s < evfc_pkg::DABBLE_STEPS; s++) begin
         for (int d = 0; d < evfc_pkg::FREQ_DIGITS; d++) begin
            if (dabble[FW + 4*d +: 4] >= 4'd5) begin
               dabble[FW + 4*d +: 4] = dabble[FW + 4*d +: 4] + 4'd3;
            end
         end
         dabble = dabble << 1;
      end
   end

   always_comb begin
      sum      = {1'b0, raw_ff} + {{(FW + 1 - evfc_pkg::STEP_W){1'b0}}, step_ff};
      divisor  = (cfg.pulses_per_level == '0) ? PW'(1) : cfg.pulses_per_level;
      acc_next = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1)
               + {{FW{1'b0}}, bcd_ff[evfc_pkg::BCD_W-1 -: 4]};
      if (raw_ff < cfg.freq_min) begin
         clamped = cfg.freq_min;
      end else if (raw_ff > cfg.freq_max) begin
         clamped = cfg.freq_max;
      end else begin
         clamped = raw_ff;
      end
      // Rounding down to 10 Hz clears the lowest decimal digit.
      rounded = {dig_ff[DW-1:4], 4'h0};
   end

   always_comb begin
      frame_byte = evfc_pkg::FRM_END;
      case (byte_idx_ff)
         evfc_pkg::POS_PRE0:  frame_byte = evfc_pkg::FRM_PREAMBLE;
         evfc_pkg::POS_PRE1:  frame_byte = evfc_pkg::FRM_PREAMBLE;
         evfc_pkg::POS_RADIO: frame_byte = cfg.radio_addr;
         evfc_pkg::POS_CTRL:  frame_byte = cfg.ctrl_addr;
         evfc_pkg::POS_CMD:   frame_byte = evfc_pkg::FRM_CMD_FREQ;
         evfc_pkg::POS_FRQ0:  frame_byte = last_sent_ff[7:0];
         evfc_pkg::POS_FRQ1:  frame_byte = last_sent_ff[15:8];
         evfc_pkg::POS_FRQ2:  frame_byte = last_sent_ff[23:16];
         evfc_pkg::POS_FRQ3:  frame_byte = last_sent_ff[31:24];
         evfc_pkg::POS_FRQ4:  frame_byte = 8'h00;
         default:             frame_byte = evfc_pkg::FRM_END;
      endcase
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign byte_last = err_ff || (byte_idx_ff == evfc_pkg::POS_END);

   always_comb begin
      state_in     = state_ff;
      raw_in       = raw_ff;
      step_in      = step_ff;
      pulse_in     = pulse_ff;
      synced_in    = synced_ff;
      last_sent_in = last_sent_ff;
      bcd_in       = bcd_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      sat_in       = sat_ff;
      shift_in     = shift_ff;
      dig_in       = dig_ff;
      byte_idx_in  = byte_idx_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_last_in  = rsp_last_ff;
      pop          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               pop = 1'b1;
               unique case (q_cmd.op)
                  evfc_pkg::OP_RIGHT: begin
                     if (pulse_ff != '1) pulse_in = pulse_ff + PW'(1);
                     raw_in   = sum[FW] ? evfc_pkg::FREQ_SAT : sum[FW-1:0];
                     state_in = ST_CLAMP;
                  end
                  evfc_pkg::OP_LEFT: begin
                     if (pulse_ff != '1) pulse_in = pulse_ff + PW'(1);
                     raw_in   = (raw_ff < FW'(step_ff)) ? '0 : raw_ff - FW'(step_ff);
                     state_in = ST_CLAMP;
                  end
                  evfc_pkg::OP_TICK: begin
                     rem_in   = pulse_ff;
                     idx_in   = '0;
                     state_in = ST_DIV;
                  end
                  evfc_pkg::OP_LOAD: begin
                     bcd_in   = q_cmd.bcd;
                     acc_in   = '0;
                     sat_in   = 1'b0;
                     cnt_in   = '0;
                     state_in = ST_LOAD;
                  end
                  evfc_pkg::OP_BAD_LOAD: begin
                     err_in      = 1'b1;
                     byte_idx_in = '0;
                     state_in    = ST_EMIT;
                  end
                  evfc_pkg::OP_RESYNC: begin
                     // Not synced afterwards, so nothing more to do.
                     synced_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_DIV: begin
            // Repeated subtraction, capped at the top table level.
            if (idx_ff < IDX_MAX && rem_ff >= divisor) begin
               rem_in = rem_ff - divisor;
               idx_in = idx_ff + evfc_pkg::IDX_W'(1);
            end else begin
               step_in  = evfc_pkg::STEP_TABLE[4'(idx_ff)];
               pulse_in = '0;
               state_in = ST_CLAMP;
            end
         end
         ST_LOAD: begin
            acc_in = acc_next[FW-1:0];
            sat_in = sat_ff || (acc_next > {4'b0, evfc_pkg::FREQ_SAT});
            bcd_in = bcd_ff << 4;
            cnt_in = cnt_ff + evfc_pkg::CNT_W'(1);
            if (cnt_ff == evfc_pkg::CNT_W'(evfc_pkg::BCD_DIGITS - 1)) begin
               raw_in    = sat_in ? evfc_pkg::FREQ_SAT : acc_next[FW-1:0];
               synced_in = 1'b1;
               state_in  = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            if (!synced_ff) begin
               state_in = ST_IDLE;
            end else begin
               raw_in   = clamped;
               shift_in = clamped;
               dig_in   = '0;
               cnt_in   = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            dig_in   = dabble[evfc_pkg::DABBLE_W-1 -: DW];
            shift_in = dabble[FW-1:0];
            cnt_in   = cnt_ff + evfc_pkg::CNT_W'(1);
            if (cnt_ff == evfc_pkg::CNT_W'(evfc_pkg::CONV_CYCLES - 1)) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (rounded == last_sent_ff) begin
               state_in = ST_IDLE;
            end else begin
               last_sent_in = rounded;
               err_in       = 1'b0;
               byte_idx_in  = '0;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = err_ff ? 8'h00 : frame_byte;
               rsp_err_in   = err_ff;
               rsp_last_in  = byte_last;
               byte_idx_in  = byte_idx_ff + evfc_pkg::BYTE_IDX_W'(1);
               if (byte_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         raw_ff       <= '0;
         step_ff      <= '0;
         pulse_ff     <= '0;
         synced_ff    <= 1'b0;
         last_sent_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         raw_ff       <= raw_in;
         step_ff      <= step_in;
         pulse_ff     <= pulse_in;
         synced_ff    <= synced_in;
         last_sent_ff <= last_sent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff      <= bcd_in;
      cnt_ff      <= cnt_in;
      rem_ff      <= rem_in;
      idx_ff      <= idx_in;
      acc_ff      <= acc_in;
      sat_ff      <= sat_in;
      shift_ff    <= shift_in;
      dig_ff      <= dig_in;
      byte_idx_ff <= byte_idx_in;
      err_ff      <= err_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = rsp_byte_ff;
   assign rsp_load_error = rsp_err_ff;
   assign rsp_last_byte  = rsp_last_ff;

endmodule

FILE: design/encoder_vfo_tuner_civ_framer_core.sv
// Encoder tuner with CI-V framing. The request side takes one item per clock while its
// two-entry queue has room; once two items wait behind a busy execution side it stalls.
// The execution side works one item at a time: a pulse is updated, clamped, converted
// from binary to BCD and compared; a tick first runs the step-level search by repeated
// subtraction, and a load first runs its digit-serial BCD decode.
// A changed frequency then sends its 11-byte frame at one byte per cycle from the
// output register while the receiver takes each byte; a rejected load returns its single
// error item instead. Configuration registers sit at byte addresses 0, 4, 8, 12 and 16
// and should only be written while idle.
module encoder_vfo_tuner_civ_framer_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [2:0]                           req_type,
   input  logic [evfc_pkg::BCD_W-1:0]           req_bcd_freq,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [7:0]                           rsp_frame_byte,
   output logic                                 rsp_load_error,
   output logic                                 rsp_last_byte,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [evfc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [evfc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [evfc_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   localparam int DW = evfc_pkg::CSR_DATA_W;

   evfc_pkg::cfg_type cfg_ff, cfg_in;
   evfc_pkg::cmd_type push_cmd;
   evfc_pkg::cmd_type q_cmd;
   logic              push, q_full, q_valid, pop;
   logic              csr_write;
   logic [2:0]        csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            evfc_pkg::CSR_RADIO_ADDR: cfg_in.radio_addr = csr_pwdata[7:0];
            evfc_pkg::CSR_CTRL_ADDR:  cfg_in.ctrl_addr  = csr_pwdata[7:0];
            evfc_pkg::CSR_FREQ_MIN:   cfg_in.freq_min   = csr_pwdata[evfc_pkg::FREQ_W-1:0];
            evfc_pkg::CSR_FREQ_MAX:   cfg_in.freq_max   = csr_pwdata[evfc_pkg::FREQ_W-1:0];
            evfc_pkg::CSR_PPL:
               cfg_in.pulses_per_level = csr_pwdata[evfc_pkg::PULSE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         evfc_pkg::CSR_RADIO_ADDR: csr_prdata = DW'(cfg_ff.radio_addr);
         evfc_pkg::CSR_CTRL_ADDR:  csr_prdata = DW'(cfg_ff.ctrl_addr);
         evfc_pkg::CSR_FREQ_MIN:   csr_prdata = DW'(cfg_ff.freq_min);
         evfc_pkg::CSR_FREQ_MAX:   csr_prdata = DW'(cfg_ff.freq_max);
         evfc_pkg::CSR_PPL:        csr_prdata = DW'(cfg_ff.pulses_per_level);
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radio_addr       <= evfc_pkg::RADIO_ADDR_RST;
         cfg_ff.ctrl_addr        <= evfc_pkg::CTRL_ADDR_RST;
         cfg_ff.freq_min         <= evfc_pkg::FREQ_MIN_RST;
         cfg_ff.freq_max         <= evfc_pkg::FREQ_MAX_RST;
         cfg_ff.pulses_per_level <= evfc_pkg::PPL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   evfc_front u_front (
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_type     (req_type),
      .req_bcd_freq (req_bcd_freq),
      .q_full       (q_full),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   evfc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd)
   );

   evfc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_valid        (q_valid),
      .q_cmd          (q_cmd),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_load_error (rsp_load_error),
      .rsp_last_byte  (rsp_last_byte)
   );

endmodule

FILE: design/evfc_checker.sv
`include "encoder_vfo_tuner_civ_framer_core_defines.svh"

module evfc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [7:0]                           rsp_frame_byte,
   input logic                                 rsp_load_error,
   input logic                                 rsp_last_byte,
   input logic                                 csr_pready
);

   // A stalled result item keeps its payload.
   `EVFC_ASSERT_RUN(a_rsp_hold,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_byte)
         && $stable(rsp_last_byte) && $stable(rsp_load_error),
      "result item changed while stalled")

   // An error item is a single zero byte that closes the event.
   `EVFC_ASSERT_RUN(a_err_item,
      rsp_valid && rsp_load_error |-> rsp_frame_byte == 8'h00 && rsp_last_byte,
      "malformed error item")

   // Frame bytes follow each other without a gap once one is taken.
   `EVFC_ASSERT_RUN(a_frame_burst, rsp_valid && rsp_ready && !rsp_last_byte |=> rsp_valid,
      "gap inside a frame")

   `EVFC_ASSERT_ALL(a_reset_idle, reset |=> !rsp_valid && csr_pready, "result pending after reset")

endmodule

bind encoder_vfo_tuner_civ_framer_core evfc_checker u_evfc_checker (.*);
